### hw/rtl/dcqb_pkg.sv
// Shared types and constants for the dual character queue balancer.
`timescale 1ns / 1ps

package dcqb_pkg;

  localparam int unsigned DEFAULT_DEPTH = 16;
  localparam int unsigned DATA_W        = 8;
  localparam int unsigned LEN_W         = 5;
  localparam int unsigned OP_W          = 3;
  localparam int unsigned IN_TDATA_W    = 8;
  localparam int unsigned IN_TUSER_W    = 4;
  localparam int unsigned OUT_TDATA_W   = 40;
  localparam int unsigned OUT_TUSER_W   = 1;

  // Byte shown for "nothing here" ('-')
  localparam logic [DATA_W-1:0] EMPTY_MARK = 8'd45;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH       = 3'd0,
    OP_PUSH_OVR   = 3'd1,
    OP_POP        = 3'd2,
    OP_PUSH_SHORT = 3'd3,
    OP_POP_LONG   = 3'd4
  } op_t;

  // Per-queue command for one step
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [DATA_W-1:0] value;
  } q_cmd_t;

  // Per-queue status: current flags/head, post-step head/tail
  typedef struct packed {
    logic              full;
    logic              empty;
    logic [DATA_W-1:0] head_cur;
    logic [DATA_W-1:0] head_nxt;
    logic [DATA_W-1:0] tail_nxt;
  } q_stat_t;

  typedef struct packed {
    logic [DATA_W-1:0] removed_value;
    logic              removed_flag;
    logic              push_dropped;
    logic              served_queue;
    logic [DATA_W-1:0] head_value;
    logic [DATA_W-1:0] tail_value;
    logic [LEN_W-1:0]  length_first;
    logic [LEN_W-1:0]  length_second;
  } result_t;

endpackage

### hw/rtl/dcqb_queue.sv
// One shift-forward byte queue: slot line, count and tail register.
`timescale 1ns / 1ps

module dcqb_queue #(
  parameter int unsigned DEPTH = dcqb_pkg::DEFAULT_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dcqb_pkg::q_cmd_t               cmd,
  output dcqb_pkg::q_stat_t              stat,
  output logic [$clog2(DEPTH+1)-1:0]     count,
  output logic [$clog2(DEPTH+1)-1:0]     count_nxt
);
  import dcqb_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(DEPTH);

  logic [DATA_W-1:0] slots_r   [DEPTH];
  logic [DATA_W-1:0] slots_nxt [DEPTH];
  logic [CNT_W-1:0]  count_r;
  logic [DATA_W-1:0] tail_r;
  logic [DATA_W-1:0] tail_nxt;
  logic [IDX_W-1:0]  wr_idx;

  // with a pop in the same step the slots move down first
  always_comb begin
    wr_idx = cmd.pop ? IDX_W'(count_r - 1'b1) : IDX_W'(count_r);
    for (int i = 0; i < DEPTH; i++) begin
      slots_nxt[i] = slots_r[i];
    end
    if (cmd.pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        slots_nxt[i] = slots_r[i+1];
      end
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (cmd.push && (wr_idx == IDX_W'(i))) begin
        slots_nxt[i] = cmd.value;
      end
    end
    count_nxt = CNT_W'(count_r + CNT_W'(cmd.push) - CNT_W'(cmd.pop));
    tail_nxt  = cmd.push ? cmd.value : tail_r;
  end

  always_comb begin
    stat.full     = (count_r == CNT_W'(DEPTH));
    stat.empty    = (count_r == '0);
    stat.head_cur = stat.empty ? EMPTY_MARK : slots_r[0];
    stat.head_nxt = (count_nxt == '0) ? EMPTY_MARK : slots_nxt[0];
    stat.tail_nxt = (count_nxt == '0) ? EMPTY_MARK : tail_nxt;
  end

  assign count = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // payload: read only behind a nonzero count
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      slots_r[i] <= slots_nxt[i];
    end
    tail_r <= tail_nxt;
  end

endmodule

### hw/rtl/dcqb_ctrl.sv
// Operation decode: queue choice, per-queue commands and result word.
`timescale 1ns / 1ps

module dcqb_ctrl #(
  parameter int unsigned DEPTH = dcqb_pkg::DEFAULT_DEPTH
) (
  input  logic                           go,
  input  dcqb_pkg::op_t                  op,
  input  logic                           queue_select,
  input  logic [dcqb_pkg::DATA_W-1:0]    value_in,
  input  dcqb_pkg::q_stat_t              stat_first,
  input  dcqb_pkg::q_stat_t              stat_second,
  input  logic [$clog2(DEPTH+1)-1:0]     cnt_first,
  input  logic [$clog2(DEPTH+1)-1:0]     cnt_second,
  input  logic [$clog2(DEPTH+1)-1:0]     cnt_first_nxt,
  input  logic [$clog2(DEPTH+1)-1:0]     cnt_second_nxt,
  output dcqb_pkg::q_cmd_t               cmd_first,
  output dcqb_pkg::q_cmd_t               cmd_second,
  output dcqb_pkg::result_t              result
);
  import dcqb_pkg::*;

  logic    sel;
  logic    do_push;
  logic    do_pop;
  logic    dropped;
  q_stat_t st;
  q_stat_t st_cur;

  always_comb begin
    unique case (op)
      OP_PUSH_SHORT: sel = (cnt_first <= cnt_second) ? 1'b0 : 1'b1;
      OP_POP_LONG:   sel = (cnt_first >= cnt_second) ? 1'b0 : 1'b1;
      default:       sel = queue_select;
    endcase
  end

  assign st_cur = sel ? stat_second : stat_first;

  always_comb begin
    do_push = 1'b0;
    do_pop  = 1'b0;
    dropped = 1'b0;
    unique case (op)
      OP_PUSH, OP_PUSH_SHORT: begin
        do_push = !st_cur.full;
        dropped = st_cur.full;
      end
      OP_PUSH_OVR: begin
        do_push = 1'b1;
        do_pop  = st_cur.full;
      end
      OP_POP, OP_POP_LONG: begin
        do_pop = !st_cur.empty;
      end
      default: ;
    endcase
  end

  always_comb begin
    cmd_first.push  = go && do_push && !sel;
    cmd_first.pop   = go && do_pop  && !sel;
    cmd_first.value = value_in;
    cmd_second.push  = go && do_push && sel;
    cmd_second.pop   = go && do_pop  && sel;
    cmd_second.value = value_in;
  end

  assign st = sel ? stat_second : stat_first;

  always_comb begin
    result.removed_value = do_pop ? st_cur.head_cur : EMPTY_MARK;
    result.removed_flag  = do_pop;
    result.push_dropped  = dropped;
    result.served_queue  = sel;
    result.head_value    = st.head_nxt;
    result.tail_value    = st.tail_nxt;
    result.length_first  = LEN_W'(cnt_first_nxt);
    result.length_second = LEN_W'(cnt_second_nxt);
  end

endmodule

### hw/rtl/dual_char_queue_balancer_top.sv
// Top level of the dual character queue balancer: stream ports and pipeline registers.
`timescale 1ns / 1ps

// Two byte queues, QUEUE_DEPTH slots each, front entry always in slot 0.
// Every input transfer carries one operation (push, push dropping the oldest
// when full, pop, push to the shorter queue, pop from the longer queue; ties
// go to the first queue) and yields exactly one result transfer with the
// removed byte, flags, the served queue's new head and tail ('-' when empty)
// and both lengths. Throughput is one item per cycle while out_tready
// allows: an input register feeds a single pass of decode plus the
// parallel slot shift/write of both queues, which lands in the result
// register. out_tvalid rises once the item has moved from the input
// register into the result register. Back pressure on out_tready stalls
// the input register; one item may wait in each stage. Queues come out of
// reset empty; no clearing sweep is needed. Plain push into a full queue is
// dropped and flagged; pop from an empty queue changes nothing.

module dual_char_queue_balancer_top #(
  parameter int unsigned QUEUE_DEPTH = dcqb_pkg::DEFAULT_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: [7:0] value_in
  input  logic [dcqb_pkg::IN_TDATA_W-1:0]     in_tdata,
  // in_tuser: [2:0] operation, [3] queue_select
  input  logic [dcqb_pkg::IN_TUSER_W-1:0]     in_tuser,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // out_tdata: [7:0] removed_value, [8] removed_flag, [9] push_dropped,
  //   [17:10] head_value, [25:18] tail_value, [30:26] length_first,
  //   [35:31] length_second, [39:36] zero
  output logic [dcqb_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // out_tuser: [0] served_queue
  output logic [dcqb_pkg::OUT_TUSER_W-1:0]    out_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready
);
  import dcqb_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  // input stage
  logic              in_valid_r;
  op_t               in_op_r;
  logic              in_sel_r;
  logic [DATA_W-1:0] in_value_r;

  // result stage
  logic    out_valid_r;
  result_t out_res_r;
  result_t res;

  logic advance;

  q_cmd_t           cmd_first, cmd_second;
  q_stat_t          stat_first, stat_second;
  logic [CNT_W-1:0] cnt_first, cnt_second;
  logic [CNT_W-1:0] cnt_first_nxt, cnt_second_nxt;

  // item moves to the result register (and commits to the queues)
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_op_r    <= op_t'(in_tuser[OP_W-1:0]);
      in_sel_r   <= in_tuser[OP_W];
      in_value_r <= in_tdata[DATA_W-1:0];
    end
  end

  dcqb_ctrl #(
    .DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .go             (advance),
    .op             (in_op_r),
    .queue_select   (in_sel_r),
    .value_in       (in_value_r),
    .stat_first     (stat_first),
    .stat_second    (stat_second),
    .cnt_first      (cnt_first),
    .cnt_second     (cnt_second),
    .cnt_first_nxt  (cnt_first_nxt),
    .cnt_second_nxt (cnt_second_nxt),
    .cmd_first      (cmd_first),
    .cmd_second     (cmd_second),
    .result         (res)
  );

  dcqb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_first (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_first),
    .stat      (stat_first),
    .count     (cnt_first),
    .count_nxt (cnt_first_nxt)
  );

  dcqb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_second (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_second),
    .stat      (stat_second),
    .count     (cnt_second),
    .count_nxt (cnt_second_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.served_queue;
  assign out_tdata  = {4'b0000,
                       out_res_r.length_second,
                       out_res_r.length_first,
                       out_res_r.tail_value,
                       out_res_r.head_value,
                       out_res_r.push_dropped,
                       out_res_r.removed_flag,
                       out_res_r.removed_value};

endmodule

### hw/rtl/dcqb_checker.sv
// Port-level checks for the dual character queue balancer, bound to the top level.
`timescale 1ns / 1ps

module dcqb_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic [dcqb_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic [dcqb_pkg::OUT_TUSER_W-1:0]   out_tuser,
  input logic                               out_tvalid,
  input logic                               out_tready
);
  import dcqb_pkg::*;

  // result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // removal and dropped push never in the same transfer
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[8] && out_tdata[9]))
    else $error("removed_flag and push_dropped both set");

  // no removal reports the empty mark
  a_removed_mark: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[8] |-> out_tdata[7:0] == EMPTY_MARK)
    else $error("removed_value set without removal");

  // an accepted item must show up as out_tvalid on the result side
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> ##2 out_tvalid)
    else $error("accepted item did not reach the result register");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind dual_char_queue_balancer_top dcqb_checker u_dcqb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

### sim/dual_char_queue_balancer_top_test.sv
// Self-checking testbench for the dual character queue balancer top level.
`timescale 1ns / 1ps

// Stimulus starts with a short table of hand-picked operations. Rows whose
// result is obvious (empty pops, unused codes, first pushes) carry a typed-in
// expectation. All other rows, and the random traffic after them, are checked
// against a behavioral copy of both queues kept in this file.
// Random traffic comes in bursts that lean toward filling, draining or mixing
// the queues, so both the full and the empty corners are reached again and
// again. Both stream sides stall at random, first mostly the receiver, then
// mostly the sender, then neither.

module dual_char_queue_balancer_top_test;
  import dcqb_pkg::*;

  localparam int unsigned DEPTH       = DEFAULT_DEPTH;
  localparam int unsigned PHASE_ITEMS = 255;   // with table rows and unused codes, ~850 in all
  localparam int unsigned END_WAIT    = 8;     // well past the result pipeline
  localparam int unsigned MAX_REPORTS = 10;

  // One directed row; reps > 1 repeats it with value_in counting up
  typedef struct {
    logic [OP_W-1:0]   op;
    logic              sel;
    logic [DATA_W-1:0] val;
    int unsigned       reps;
    bit                typed;
    result_t           want;
  } plan_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;

  // Shadow copy of both queues; index 0 is the first queue
  logic [DATA_W-1:0] held [2][DEPTH];
  int unsigned       fill [2];

  result_t     expected_status [$];
  int unsigned mismatch_count = 0;
  int unsigned src_idle  = 0;   // percent of cycles the sender holds off
  int unsigned sink_idle = 0;   // percent of cycles the receiver stalls

  dual_char_queue_balancer_top #(
    .QUEUE_DEPTH(DEPTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Remove the front byte of a queue; vacated slot goes back to the mark
  function automatic logic [DATA_W-1:0] pull_front(int unsigned q);
    logic [DATA_W-1:0] front;
    int unsigned       i;
    front = held[q][0];
    for (i = 0; i + 1 < fill[q]; i++) held[q][i] = held[q][i + 1];
    held[q][fill[q] - 1] = EMPTY_MARK;
    fill[q]--;
    return front;
  endfunction

  // Apply one operation to the shadow queues and return the status it gives
  function automatic result_t next_queue_status(logic [OP_W-1:0] op, logic sel,
                                                logic [DATA_W-1:0] val);
    result_t     r;
    int unsigned q;
    r = '0;
    r.removed_value = EMPTY_MARK;
    q = sel;
    // balancing ops pick their own queue, first queue wins ties
    if (op == OP_PUSH_SHORT) q = (fill[0] <= fill[1]) ? 0 : 1;
    else if (op == OP_POP_LONG) q = (fill[0] >= fill[1]) ? 0 : 1;
    case (op)
      OP_PUSH, OP_PUSH_SHORT: begin
        if (fill[q] == DEPTH) begin
          r.push_dropped = 1'b1;
        end else begin
          held[q][fill[q]] = val;
          fill[q]++;
        end
      end
      OP_PUSH_OVR: begin
        if (fill[q] == DEPTH) begin
          r.removed_value = pull_front(q);
          r.removed_flag  = 1'b1;
        end
        held[q][fill[q]] = val;
        fill[q]++;
      end
      OP_POP, OP_POP_LONG: begin
        if (fill[q] != 0) begin
          r.removed_value = pull_front(q);
          r.removed_flag  = 1'b1;
        end
      end
      default: ;  // unused codes leave both queues alone
    endcase
    r.served_queue  = q[0];
    r.head_value    = (fill[q] != 0) ? held[q][0] : EMPTY_MARK;
    r.tail_value    = (fill[q] != 0) ? held[q][fill[q] - 1] : EMPTY_MARK;
    r.length_first  = LEN_W'(fill[0]);
    r.length_second = LEN_W'(fill[1]);
    return r;
  endfunction

  function automatic result_t status_from_bus(logic [OUT_TDATA_W-1:0] d,
                                              logic [OUT_TUSER_W-1:0] u);
    result_t r;
    r.removed_value = d[7:0];
    r.removed_flag  = d[8];
    r.push_dropped  = d[9];
    r.head_value    = d[17:10];
    r.tail_value    = d[25:18];
    r.length_first  = d[30:26];
    r.length_second = d[35:31];
    r.served_queue  = u[0];
    return r;
  endfunction

  function automatic result_t mk_status(logic [7:0] rv, logic rf, logic pd, logic sq,
                                        logic [7:0] hd, logic [7:0] tl,
                                        logic [4:0] l1, logic [4:0] l2);
    result_t r;
    r.removed_value = rv;
    r.removed_flag  = rf;
    r.push_dropped  = pd;
    r.served_queue  = sq;
    r.head_value    = hd;
    r.tail_value    = tl;
    r.length_first  = l1;
    r.length_second = l2;
    return r;
  endfunction

  function automatic plan_row_t mk_row(logic [OP_W-1:0] op, logic sel, logic [7:0] val,
                                       int unsigned reps, bit typed, result_t want);
    plan_row_t row;
    row.op    = op;
    row.sel   = sel;
    row.val   = val;
    row.reps  = reps;
    row.typed = typed;
    row.want  = want;
    return row;
  endfunction

  // Receiver stall pattern; redrawn every cycle
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_idle);
  end

  // Result checker: values read here are the ones present before the edge
  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen = status_from_bus(out_tdata, out_tuser);
      if (expected_status.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: result transfer with nothing expected: tdata=%h tuser=%h",
                   $realtime, out_tdata, out_tuser);
      end else begin
        want = expected_status.pop_front();
        if (seen.removed_value !== want.removed_value ||
            seen.removed_flag  !== want.removed_flag  ||
            seen.push_dropped  !== want.push_dropped  ||
            seen.served_queue  !== want.served_queue  ||
            seen.head_value    !== want.head_value    ||
            seen.tail_value    !== want.tail_value    ||
            seen.length_first  !== want.length_first  ||
            seen.length_second !== want.length_second) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: status mismatch (rm val/flag drop q head tail len0 len1)",
                     $realtime);
            $display("  expected %h %b %b %b %h %h %0d %0d", want.removed_value,
                     want.removed_flag, want.push_dropped, want.served_queue,
                     want.head_value, want.tail_value, want.length_first,
                     want.length_second);
            $display("  actual   %h %b %b %b %h %h %0d %0d", seen.removed_value,
                     seen.removed_flag, seen.push_dropped, seen.served_queue,
                     seen.head_value, seen.tail_value, seen.length_first,
                     seen.length_second);
          end
        end
      end
    end
  end

  // Offer one item, wait for its transfer, then log what it should produce.
  // in_tvalid is left high so a following item can go back to back.
  task automatic send_item(logic [OP_W-1:0] op, logic sel, logic [DATA_W-1:0] val,
                           bit typed, result_t want);
    result_t pred;
    while ($urandom_range(99) < src_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= val;
    in_tuser  <= {sel, op};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = next_queue_status(op, sel, val);
    expected_status.push_back(typed ? want : pred);
  endtask

  // Sender holds off until every outstanding result has come back.
  // Always waits on the clock before checking, so in_tvalid is not raised in this step.
  task automatic settle_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_status.size() != 0) @(posedge clk);
  endtask

  // Bursty random traffic; unused codes are sprinkled in but not counted
  task automatic random_phase(int unsigned items);
    int unsigned     done;
    int unsigned     burst;
    int unsigned     mode;
    int unsigned     r;
    logic [OP_W-1:0] op;
    done  = 0;
    burst = 0;
    mode  = 0;
    while (done < items) begin
      if (burst == 0) begin
        burst = $urandom_range(60, 10);
        mode  = $urandom_range(2);     // 0 fill, 1 drain, 2 mixed
      end
      burst--;
      r = $urandom_range(99);
      if (r < 5) begin
        op = OP_W'($urandom_range(7, 5));
      end else begin
        r = $urandom_range(99);
        case (mode)
          0: op = (r < 45) ? OP_PUSH : (r < 60) ? OP_PUSH_SHORT :
                  (r < 75) ? OP_PUSH_OVR : (r < 88) ? OP_POP : OP_POP_LONG;
          1: op = (r < 15) ? OP_PUSH : (r < 25) ? OP_PUSH_SHORT :
                  (r < 35) ? OP_PUSH_OVR : (r < 70) ? OP_POP : OP_POP_LONG;
          default:
             op = (r < 20) ? OP_PUSH : (r < 40) ? OP_PUSH_SHORT :
                  (r < 60) ? OP_PUSH_OVR : (r < 80) ? OP_POP : OP_POP_LONG;
        endcase
      end
      send_item(op, 1'($urandom_range(1)), DATA_W'($urandom_range(255)), 1'b0, '0);
      if (op <= OP_POP_LONG) done++;
    end
  endtask

  initial begin
    plan_row_t   plan [$];
    int unsigned k;
    int unsigned q;
    int unsigned i;

    for (q = 0; q < 2; q++) begin
      fill[q] = 0;
      for (i = 0; i < DEPTH; i++) held[q][i] = EMPTY_MARK;
    end

    // Directed rows. Typed expectations only where the answer is plain.
    // Empty pops, pop-longer on two empty queues, an unused code
    plan.push_back(mk_row(OP_POP, 1'b0, 8'h00, 1, 1'b1,
                          mk_status(EMPTY_MARK, 0, 0, 0, EMPTY_MARK, EMPTY_MARK, 0, 0)));
    plan.push_back(mk_row(OP_POP, 1'b1, 8'hFF, 1, 1'b1,
                          mk_status(EMPTY_MARK, 0, 0, 1, EMPTY_MARK, EMPTY_MARK, 0, 0)));
    plan.push_back(mk_row(OP_POP_LONG, 1'b1, 8'h00, 1, 1'b1,
                          mk_status(EMPTY_MARK, 0, 0, 0, EMPTY_MARK, EMPTY_MARK, 0, 0)));
    plan.push_back(mk_row(3'd7, 1'b1, 8'hFF, 1, 1'b1,
                          mk_status(EMPTY_MARK, 0, 0, 1, EMPTY_MARK, EMPTY_MARK, 0, 0)));
    // Extreme bytes into each queue
    plan.push_back(mk_row(OP_PUSH, 1'b0, 8'h00, 1, 1'b1,
                          mk_status(EMPTY_MARK, 0, 0, 0, 8'h00, 8'h00, 1, 0)));
    plan.push_back(mk_row(OP_PUSH, 1'b1, 8'hFF, 1, 1'b1,
                          mk_status(EMPTY_MARK, 0, 0, 1, 8'hFF, 8'hFF, 1, 1)));
    // Push-shorter: tie goes first, then the second is shorter
    plan.push_back(mk_row(OP_PUSH_SHORT, 1'b1, 8'h80, 1, 1'b1,
                          mk_status(EMPTY_MARK, 0, 0, 0, 8'h00, 8'h80, 2, 1)));
    plan.push_back(mk_row(OP_PUSH_SHORT, 1'b0, 8'h7F, 1, 1'b1,
                          mk_status(EMPTY_MARK, 0, 0, 1, 8'hFF, 8'h7F, 2, 2)));
    // Pop-longer: tie goes first, then the second is longer
    plan.push_back(mk_row(OP_POP_LONG, 1'b1, 8'h00, 1, 1'b1,
                          mk_status(8'h00, 1, 0, 0, 8'h80, 8'h80, 1, 2)));
    plan.push_back(mk_row(OP_POP_LONG, 1'b0, 8'h00, 1, 1'b1,
                          mk_status(8'hFF, 1, 0, 1, 8'h7F, 8'h7F, 1, 1)));
    // Overwrite push with room left acts as a plain push
    plan.push_back(mk_row(OP_PUSH_OVR, 1'b1, EMPTY_MARK, 1, 1'b1,
                          mk_status(EMPTY_MARK, 0, 0, 1, 8'h7F, EMPTY_MARK, 1, 2)));
    // Fill the first queue, push into it full, overwrite the oldest
    plan.push_back(mk_row(OP_PUSH, 1'b0, 8'h01, DEPTH - 1, 1'b0, '0));
    plan.push_back(mk_row(OP_PUSH, 1'b0, 8'h55, 1, 1'b0, '0));
    plan.push_back(mk_row(OP_PUSH_OVR, 1'b0, 8'hA5, 1, 1'b0, '0));
    // Fill the second as well; push-shorter with both full is dropped
    plan.push_back(mk_row(OP_PUSH, 1'b1, 8'h30, DEPTH - 2, 1'b0, '0));
    plan.push_back(mk_row(OP_PUSH_SHORT, 1'b0, 8'h99, 1, 1'b0, '0));
    plan.push_back(mk_row(OP_PUSH_OVR, 1'b1, 8'hC3, 1, 1'b0, '0));
    plan.push_back(mk_row(OP_POP_LONG, 1'b0, 8'h00, 2, 1'b0, '0));

    src_idle  = 38;
    sink_idle = 75;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[r]) begin
      for (k = 0; k < plan[r].reps; k++)
        send_item(plan[r].op, plan[r].sel, DATA_W'(plan[r].val + k),
                  plan[r].typed, plan[r].want);
    end
    settle_results();

    // mostly receiver stalls
    random_phase(PHASE_ITEMS);
    settle_results();

    // mostly sender gaps
    src_idle  = 75;
    sink_idle = 38;
    random_phase(PHASE_ITEMS);
    settle_results();

    // full rate both ways
    src_idle  = 0;
    sink_idle = 0;
    random_phase(PHASE_ITEMS - 2);
    settle_results();

    // catch any stray transfer after the last expected one
    repeat (END_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (about 2 ms)
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
